// File: hw/rtl/crw_pkg.sv
// ----------------------------------------------------------------------------
// crw_pkg
// Shared types, codes and sizes for the graph random walker.
// ----------------------------------------------------------------------------
`default_nettype none

package crw_pkg;

  // default sizes of the graph stores
  localparam int unsigned MAX_NODES  = 65536;
  localparam int unsigned MAX_EDGES  = 262144;
  localparam int unsigned MAX_DEGREE = 1024;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 18;
  localparam int unsigned VALUE_W  = 19;
  localparam int unsigned RAND_W   = 31;
  localparam int unsigned NODE_W   = 16;
  localparam int unsigned WALK_W   = 10;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEG_W    = 19;
  localparam int unsigned PERM_W   = 10;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NO_REPLACE = 2'd0,
    CFG_WALKS      = 2'd1,
    CFG_STEPS      = 2'd2
  } cfg_index_t;

  localparam logic [WALK_W-1:0] WALKS_RESET = 10'd100;
  localparam logic [POS_W-1:0]  STEPS_RESET = 8'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_ROW  = 2'd0,
    KIND_LOAD_NBR  = 2'd1,
    KIND_SEED      = 2'd2,
    KIND_DRAW      = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NODE     = 2'd0,
    ST_SWAP     = 2'd1,
    ST_NO_SEED  = 2'd2,
    ST_TOO_WIDE = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
    logic [RAND_W-1:0]  rand_word;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node;
    logic [WALK_W-1:0]   walk_number;
    logic [POS_W-1:0]    position;
    logic                seed_finished;
    logic                last;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RS_LO,
    S_RS_HI,
    S_RS_DEG,
    S_CLEAR,
    S_DRAW,
    S_SW_DIV,
    S_SW_RD_A,
    S_SW_RD_B,
    S_SW_WR_K,
    S_SW_WR_S,
    S_EMIT_ONE,
    S_EMIT_SEED,
    S_IDX_SEL,
    S_IDX_DIV,
    S_PERM_WAIT,
    S_NB_RD,
    S_NB_WAIT,
    S_FINAL
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/crw_stream_if.sv
// ----------------------------------------------------------------------------
// crw_stream_if
// Valid/ready channel carrying one request or result of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface crw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/csr_graph_random_walker.sv
// ----------------------------------------------------------------------------
// csr_graph_random_walker
// Random-walk sampler over a graph held as row starts and neighbor lists.
// ----------------------------------------------------------------------------
// A seed request reads the seed's row bounds and then sweeps the
// permutation store, one entry a cycle, before the next request is taken.
// Draw requests share one remainder unit: a hop does row reads, remainder,
// neighbor read and result, a shuffle swap a remainder and the swap, while a
// first hop by permuted index and a draw that is refused (no active seed,
// oversized degree) do without it; a full result register holds each result
// back until it is taken.
`default_nettype none

module csr_graph_random_walker #(
  parameter int unsigned MAX_NODES  = crw_pkg::MAX_NODES,
  parameter int unsigned MAX_EDGES  = crw_pkg::MAX_EDGES,
  parameter int unsigned MAX_DEGREE = crw_pkg::MAX_DEGREE
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [crw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crw_pkg::CFG_DATA_W-1:0] cfg_data,
  crw_stream_if.sink                          item,
  crw_stream_if.source                        result
);

  localparam int unsigned RA = $clog2(MAX_NODES + 1);
  localparam int unsigned NA = $clog2(MAX_EDGES);
  localparam int unsigned PA = $clog2(MAX_DEGREE);
  localparam int unsigned DW = crw_pkg::DEG_W;
  localparam int unsigned WW = crw_pkg::WALK_W;
  localparam int unsigned PW = crw_pkg::PERM_W;
  localparam int unsigned NW = crw_pkg::NODE_W;

  crw_pkg::state_t state, state_next;

  // configuration registers
  logic          no_replace;
  logic [WW-1:0] walks_cfg;
  logic [7:0]    steps_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_replace <= 1'b0;
      walks_cfg  <= crw_pkg::WALKS_RESET;
      steps_cfg  <= crw_pkg::STEPS_RESET;
    end else if (cfg_we) begin
      case (crw_pkg::cfg_index_t'(cfg_index))
        crw_pkg::CFG_NO_REPLACE: no_replace <= cfg_data[0];
        crw_pkg::CFG_WALKS:      walks_cfg  <= cfg_data[WW-1:0];
        crw_pkg::CFG_STEPS:      steps_cfg  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // walk state
  logic [NW-1:0]             seed_id, current, rd_node;
  logic [DW-1:0]             seed_degree, seed_base, base, deg_r, idx, s_r;
  logic [WW-1:0]             walk_cnt, swap_cnt;
  logic [7:0]                step_cnt;
  logic                      seed_active, for_seed, nb_ok;
  logic [PW-1:0]             a_val;
  logic [PA-1:0]             clr_cnt;
  logic [crw_pkg::RAND_W-1:0] rnd;

  // result register
  logic             res_valid;
  crw_pkg::result_t res_data;
  logic             slot_free, emit;
  crw_pkg::result_t emit_data;

  assign slot_free    = !res_valid || result.ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;
  assign item.ready   = (state == crw_pkg::S_IDLE);

  logic accept;
  assign accept = item.valid && item.ready;

  // memory ports
  logic          rs_we, nb_we, perm_we;
  logic [RA-1:0] rs_waddr, rs_raddr;
  logic [DW-1:0] rs_wdata, rs_rdata;
  logic [NA-1:0] nb_waddr, nb_raddr;
  logic [NW-1:0] nb_wdata, nb_rdata;
  logic [PA-1:0] perm_waddr, perm_raddr;
  logic [PW:0]   perm_wdata, perm_rdata;

  crw_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 1)) u_row_ram (
    .clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  crw_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_nbr_ram (
    .clk, .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  // permutation entries carry a written flag above the value
  crw_ram #(.WIDTH(PW + 1), .DEPTH(MAX_DEGREE)) u_perm_ram (
    .clk, .we(perm_we), .waddr(perm_waddr), .wdata(perm_wdata),
    .raddr(perm_raddr), .rdata(perm_rdata)
  );

  // shared remainder unit
  logic                       div_start, div_done;
  logic [crw_pkg::RAND_W-1:0] div_dividend;
  logic [DW-1:0]              div_divisor, div_rem;

  crw_divider u_div (
    .clk, .rst, .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .remainder(div_rem)
  );

  // draw decision helpers
  logic [WW-1:0] walks_eff;
  logic [7:0]    steps_eff;
  logic          shuffled, oversized, do_swap, first_hop, use_perm;
  logic          lo_ok, hi_ok;
  logic [DW-1:0] hi_val, deg_calc;
  logic [DW:0]   nb_sum;
  logic [PW-1:0] perm_k_val, perm_wc_val;
  logic [8:0]    step_inc;
  logic [WW:0]   walk_inc;

  assign walks_eff  = (walks_cfg == '0) ? WW'(1) : walks_cfg;
  assign steps_eff  = (steps_cfg == '0) ? 8'd1 : steps_cfg;
  assign shuffled   = no_replace && (seed_degree > DW'(walks_eff));
  assign oversized  = 32'(seed_degree) > MAX_DEGREE;
  assign do_swap    = shuffled && walk_cnt == '0 && step_cnt == '0 && swap_cnt < walks_eff;
  assign first_hop  = (step_cnt == '0);
  assign use_perm   = no_replace && (deg_r > DW'(walks_eff));
  assign lo_ok      = 32'(rd_node) <= MAX_NODES;
  assign hi_ok      = 32'(rd_node) < MAX_NODES;
  assign hi_val     = hi_ok ? rs_rdata : '0;
  assign deg_calc   = (hi_val > base) ? hi_val - base : '0;
  assign nb_sum     = (DW + 1)'(base) + (DW + 1)'(idx);
  assign perm_k_val = perm_rdata[PW] ? perm_rdata[PW-1:0] : swap_cnt;
  assign perm_wc_val = (perm_rdata[PW] && 32'(walk_cnt) < MAX_DEGREE)
                     ? perm_rdata[PW-1:0] : walk_cnt;
  assign step_inc   = 9'(step_cnt) + 9'd1;
  assign walk_inc   = (WW + 1)'(walk_cnt) + (WW + 1)'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crw_pkg::S_IDLE: begin
        if (accept) begin
          if (item.data.kind == crw_pkg::KIND_SEED) begin
            state_next = crw_pkg::S_RS_LO;
          end else if (item.data.kind == crw_pkg::KIND_DRAW) begin
            state_next = crw_pkg::S_DRAW;
          end
        end
      end
      crw_pkg::S_RS_LO: state_next = crw_pkg::S_RS_HI;
      crw_pkg::S_RS_HI: state_next = crw_pkg::S_RS_DEG;
      crw_pkg::S_RS_DEG: begin
        state_next = for_seed ? crw_pkg::S_CLEAR : crw_pkg::S_IDX_SEL;
      end
      crw_pkg::S_CLEAR: begin
        if (clr_cnt == PA'(MAX_DEGREE - 1)) begin
          state_next = crw_pkg::S_IDLE;
        end
      end
      crw_pkg::S_DRAW: begin
        if (!seed_active || (shuffled && oversized)) begin
          state_next = crw_pkg::S_EMIT_ONE;
        end else if (do_swap) begin
          state_next = crw_pkg::S_SW_DIV;
        end else if (first_hop) begin
          state_next = crw_pkg::S_EMIT_SEED;
        end else begin
          state_next = crw_pkg::S_RS_LO;
        end
      end
      crw_pkg::S_SW_DIV: if (div_done) state_next = crw_pkg::S_SW_RD_A;
      crw_pkg::S_SW_RD_A: state_next = crw_pkg::S_SW_RD_B;
      crw_pkg::S_SW_RD_B: state_next = crw_pkg::S_SW_WR_K;
      crw_pkg::S_SW_WR_K: state_next = crw_pkg::S_SW_WR_S;
      crw_pkg::S_SW_WR_S: state_next = crw_pkg::S_EMIT_ONE;
      crw_pkg::S_EMIT_ONE: if (slot_free) state_next = crw_pkg::S_IDLE;
      crw_pkg::S_EMIT_SEED: if (slot_free) state_next = crw_pkg::S_IDX_SEL;
      crw_pkg::S_IDX_SEL: begin
        if (deg_r == '0) begin
          state_next = crw_pkg::S_FINAL;
        end else if (first_hop && use_perm) begin
          state_next = crw_pkg::S_PERM_WAIT;
        end else begin
          state_next = crw_pkg::S_IDX_DIV;
        end
      end
      crw_pkg::S_IDX_DIV: if (div_done) state_next = crw_pkg::S_NB_RD;
      crw_pkg::S_PERM_WAIT: state_next = crw_pkg::S_NB_RD;
      crw_pkg::S_NB_RD: state_next = crw_pkg::S_NB_WAIT;
      crw_pkg::S_NB_WAIT: state_next = crw_pkg::S_FINAL;
      crw_pkg::S_FINAL: if (slot_free) state_next = crw_pkg::S_IDLE;
      default: state_next = crw_pkg::S_IDLE;
    endcase
  end

  // memory, divider and result controls
  always_comb begin
    rs_we        = 1'b0;
    rs_waddr     = RA'(item.data.address);
    rs_wdata     = item.data.value;
    rs_raddr     = RA'(rd_node);
    nb_we        = 1'b0;
    nb_waddr     = NA'(item.data.address);
    nb_wdata     = item.data.value[NW-1:0];
    nb_raddr     = NA'(nb_sum);
    perm_we      = 1'b0;
    perm_waddr   = clr_cnt;
    perm_wdata   = '0;
    perm_raddr   = PA'(swap_cnt);
    div_start    = 1'b0;
    div_dividend = rnd;
    div_divisor  = seed_degree - DW'(swap_cnt);
    emit         = 1'b0;
    emit_data    = '0;
    emit_data.last = 1'b1;
    case (state)
      crw_pkg::S_IDLE: begin
        rs_we = accept && item.data.kind == crw_pkg::KIND_LOAD_ROW
             && 32'(item.data.address) <= MAX_NODES;
        nb_we = accept && item.data.kind == crw_pkg::KIND_LOAD_NBR
             && 32'(item.data.address) < MAX_EDGES;
      end
      crw_pkg::S_RS_HI: rs_raddr = RA'(17'(rd_node) + 17'd1);
      crw_pkg::S_CLEAR: perm_we = 1'b1;
      crw_pkg::S_DRAW: div_start = seed_active && !(shuffled && oversized) && do_swap;
      crw_pkg::S_SW_RD_A: perm_raddr = PA'(swap_cnt);
      crw_pkg::S_SW_RD_B: perm_raddr = PA'(s_r);
      crw_pkg::S_SW_WR_K: begin
        perm_we    = 1'b1;
        perm_waddr = PA'(swap_cnt);
        perm_wdata = {1'b1, perm_rdata[PW] ? perm_rdata[PW-1:0] : PW'(s_r)};
      end
      crw_pkg::S_SW_WR_S: begin
        perm_we    = 1'b1;
        perm_waddr = PA'(s_r);
        perm_wdata = {1'b1, a_val};
      end
      crw_pkg::S_EMIT_ONE: begin
        emit = slot_free;
        if (!seed_active) begin
          emit_data.status = crw_pkg::ST_NO_SEED;
        end else if (shuffled && oversized) begin
          emit_data.status = crw_pkg::ST_TOO_WIDE;
        end else begin
          emit_data.status = crw_pkg::ST_SWAP;
        end
      end
      crw_pkg::S_EMIT_SEED: begin
        emit                  = slot_free;
        emit_data.status      = crw_pkg::ST_NODE;
        emit_data.node        = seed_id;
        emit_data.walk_number = walk_cnt;
        emit_data.last        = 1'b0;
      end
      crw_pkg::S_IDX_SEL: begin
        perm_raddr  = PA'(walk_cnt);
        div_divisor = deg_r;
        if (deg_r != '0 && !(first_hop && use_perm)) begin
          div_start = 1'b1;
          if (first_hop && no_replace) begin
            div_dividend = crw_pkg::RAND_W'(walk_cnt);
          end
        end
      end
      crw_pkg::S_FINAL: begin
        emit                    = slot_free;
        emit_data.status        = crw_pkg::ST_NODE;
        emit_data.node          = current;
        emit_data.walk_number   = walk_cnt;
        emit_data.position      = step_inc[7:0];
        emit_data.seed_finished = (step_inc >= 9'(steps_eff))
                               && (walk_inc >= (WW + 1)'(walks_eff));
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crw_pkg::S_IDLE;
      res_valid   <= 1'b0;
      seed_active <= 1'b0;
      seed_id     <= '0;
      current     <= '0;
      seed_degree <= '0;
      walk_cnt    <= '0;
      step_cnt    <= '0;
      swap_cnt    <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        crw_pkg::S_IDLE: begin
          if (accept && item.data.kind == crw_pkg::KIND_SEED) begin
            seed_id     <= item.data.value[NW-1:0];
            current     <= item.data.value[NW-1:0];
            walk_cnt    <= '0;
            step_cnt    <= '0;
            swap_cnt    <= '0;
            seed_active <= 1'b1;
          end
        end
        crw_pkg::S_RS_DEG: if (for_seed) seed_degree <= deg_calc;
        crw_pkg::S_SW_WR_S: swap_cnt <= swap_cnt + 1'b1;
        crw_pkg::S_EMIT_SEED: if (slot_free) current <= seed_id;
        crw_pkg::S_NB_WAIT: current <= nb_ok ? nb_rdata : '0;
        crw_pkg::S_FINAL: begin
          if (slot_free) begin
            if (step_inc >= 9'(steps_eff)) begin
              step_cnt <= '0;
              if (walk_inc >= (WW + 1)'(walks_eff)) begin
                walk_cnt    <= '0;
                seed_active <= 1'b0;
              end else begin
                walk_cnt <= walk_inc[WW-1:0];
              end
            end else begin
              step_cnt <= step_inc[7:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      res_data <= emit_data;
    end
    case (state)
      crw_pkg::S_IDLE: begin
        rnd      <= item.data.rand_word;
        rd_node  <= item.data.value[NW-1:0];
        for_seed <= 1'b1;
        clr_cnt  <= '0;
      end
      crw_pkg::S_RS_HI: base <= lo_ok ? rs_rdata : '0;
      crw_pkg::S_RS_DEG: begin
        deg_r <= deg_calc;
        if (for_seed) begin
          seed_base <= base;
        end
      end
      crw_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
      crw_pkg::S_DRAW: begin
        rd_node  <= current;
        for_seed <= 1'b0;
      end
      crw_pkg::S_SW_DIV: if (div_done) s_r <= div_rem + DW'(swap_cnt);
      crw_pkg::S_SW_RD_B: a_val <= perm_k_val;
      crw_pkg::S_EMIT_SEED: begin
        deg_r <= seed_degree;
        base  <= seed_base;
      end
      crw_pkg::S_IDX_DIV: if (div_done) idx <= div_rem;
      crw_pkg::S_PERM_WAIT: idx <= DW'(perm_wc_val);
      crw_pkg::S_NB_RD: nb_ok <= 32'(nb_sum) < MAX_EDGES;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/crw_ram.sv
// ----------------------------------------------------------------------------
// crw_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/crw_divider.sv
// ----------------------------------------------------------------------------
// crw_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crw_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [crw_pkg::RAND_W-1:0] dividend,
  input  wire logic [crw_pkg::DEG_W-1:0]  divisor,
  output logic                            done,
  output logic      [crw_pkg::DEG_W-1:0]  remainder
);

  localparam int unsigned CW = $clog2(crw_pkg::RAND_W + 1);

  logic [crw_pkg::DEG_W:0]    rem;
  logic [crw_pkg::RAND_W-1:0] shift;
  logic [crw_pkg::DEG_W-1:0]  dsr;
  logic [CW-1:0]              cnt;
  logic [crw_pkg::DEG_W:0]    trial;

  // shift in the next dividend bit
  assign trial = {rem[crw_pkg::DEG_W-1:0], shift[crw_pkg::RAND_W-1]};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(crw_pkg::RAND_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
      dsr   <= divisor;
    end else if (cnt != '0) begin
      shift <= {shift[crw_pkg::RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= trial - {1'b0, dsr};
      end else begin
        rem <= trial;
      end
    end
  end

  assign remainder = rem[crw_pkg::DEG_W-1:0];

endmodule

`default_nettype wire
